// File: sv/sbp_pkg.sv
// shared types and constants for the sextet bit packer
// no dependencies; imported by every module of the block
package sbp_pkg;

    localparam int OP_W     = 2;
    localparam int WORD_W   = 32;
    localparam int BYTE_W   = 8;
    localparam int SEXTET_W = 6;
    localparam int PEND_W   = SEXTET_W - 1;          // at most five bits wait
    localparam int CNT_W    = 3;                     // pending count, 0 to 5
    localparam int ACC_W    = PEND_W + WORD_W;       // pending bits plus a word
    localparam int TOT_W    = 6;                     // bit count up to ACC_W
    localparam int OUT_W    = 8;                     // sextet padded to a byte
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = 1;
    localparam int QCNT_W   = 2;

    localparam logic [OP_W-1:0] OP_BYTE  = 2'd0;
    localparam logic [OP_W-1:0] OP_WORD  = 2'd1;
    localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

    // one classified item on its way from front to back
    typedef struct packed {
        logic              flush;
        logic              word;
        logic [WORD_W-1:0] data;   // byte items already masked to 8 bits
    } sbp_entry_t;

endpackage

// File: sv/sbp_front.sv
// front end: accepts input beats, decodes the operation and masks the data
// depends on sbp_pkg
module sbp_front (
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [31:0]               s_axis_tdata,   // value
    input  logic [1:0]                s_axis_tuser,   // operation
    input  logic                      q_full,
    output logic                      q_push,
    output sbp_pkg::sbp_entry_t       q_entry
);
    import sbp_pkg::*;

    logic keep;

    always_comb
    begin
        keep          = 1'b0;
        q_entry.flush = 1'b0;
        q_entry.word  = 1'b0;
        q_entry.data  = s_axis_tdata;
        unique case (s_axis_tuser)
            OP_BYTE:
            begin
                keep         = 1'b1;
                q_entry.data = {{(WORD_W-BYTE_W){1'b0}}, s_axis_tdata[BYTE_W-1:0]};
            end
            OP_WORD:
            begin
                keep         = 1'b1;
                q_entry.word = 1'b1;
            end
            OP_FLUSH:
            begin
                keep          = 1'b1;
                q_entry.flush = 1'b1;
            end
            default:
            begin
                // unused code: beat is taken and dropped
                keep = 1'b0;
            end
        endcase
    end

    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && !q_full && keep;

endmodule

// File: sv/sbp_queue.sv
// two-entry queue of classified items between front and back
// depends on sbp_pkg
module sbp_queue (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  sbp_pkg::sbp_entry_t       push_entry,
    output logic                      full,
    input  logic                      pop,
    output logic                      head_valid,
    output sbp_pkg::sbp_entry_t       head_entry
);
    import sbp_pkg::*;

    sbp_entry_t          slot_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    assign full       = (count_reg == QCNT_W'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: sv/sbp_back.sv
// back end: bit accumulator that emits one sextet per cycle, unless the output stalls, into an output register
// depends on sbp_pkg
module sbp_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_valid,
    input  sbp_pkg::sbp_entry_t       q_entry,
    output logic                      q_pop,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [7:0]                m_axis_tdata,   // sextet, zero padded
    output logic                      m_axis_tlast
);
    import sbp_pkg::*;

    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic [TOT_W-1:0]    total_reg, total_next;
    logic                flush_reg, flush_next;
    logic                out_valid_reg, out_valid_next;
    logic [SEXTET_W-1:0] out_data_reg, out_data_next;
    logic                out_last_reg, out_last_next;

    logic                busy;
    logic                emit_last;
    logic                slot_free;
    logic                emit_fire;
    logic                free_now;
    logic [ACC_W-1:0]    post_acc;
    logic [TOT_W-1:0]    post_total;
    logic [ACC_W-1:0]    rem_acc;
    logic [CNT_W-1:0]    rem_cnt;
    logic [ACC_W-1:0]    load_acc;
    logic [TOT_W-1:0]    load_total;

    always_comb
    begin
        busy       = flush_reg || (total_reg >= TOT_W'(SEXTET_W));
        emit_last  = flush_reg || (total_reg < TOT_W'(2 * SEXTET_W));
        slot_free  = !out_valid_reg || m_axis_tready;
        emit_fire  = busy && slot_free;
        free_now   = !busy || (emit_fire && emit_last);

        post_acc   = flush_reg ? '0 : (acc_reg >> SEXTET_W);
        post_total = flush_reg ? '0 : (total_reg - TOT_W'(SEXTET_W));

        // what is left over for the next item, always below one sextet
        rem_acc    = emit_fire ? post_acc : acc_reg;
        rem_cnt    = emit_fire ? post_total[CNT_W-1:0] : total_reg[CNT_W-1:0];

        load_acc   = ({{PEND_W{1'b0}}, q_entry.data} << rem_cnt)
                   | {{WORD_W{1'b0}}, rem_acc[PEND_W-1:0]};
        load_total = {{(TOT_W-CNT_W){1'b0}}, rem_cnt}
                   + (q_entry.word ? TOT_W'(WORD_W) : TOT_W'(BYTE_W));

        q_pop      = free_now && q_valid;

        acc_next   = acc_reg;
        total_next = total_reg;
        flush_next = flush_reg;
        if (emit_fire)
        begin
            acc_next   = post_acc;
            total_next = post_total;
            flush_next = 1'b0;
        end
        if (q_pop)
        begin
            if (q_entry.flush)
            begin
                // flush with nothing pending just clears
                acc_next   = rem_acc;
                total_next = {{(TOT_W-CNT_W){1'b0}}, rem_cnt};
                flush_next = (rem_cnt != '0);
            end
            else
            begin
                acc_next   = load_acc;
                total_next = load_total;
                flush_next = 1'b0;
            end
        end

        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        if (emit_fire)
        begin
            out_valid_next = 1'b1;
            out_data_next  = acc_reg[SEXTET_W-1:0];
            out_last_next  = emit_last;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            total_reg     <= '0;
            flush_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            total_reg     <= total_next;
            flush_reg     <= flush_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_W-SEXTET_W){1'b0}}, out_data_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

// File: sv/sextet_bit_packer.sv
// top level of the sextet bit packer: front decoder, item queue, bit accumulator
// depends on sbp_pkg, sbp_front, sbp_queue, sbp_back
//
// Packs bytes or 32-bit words into 6-bit sextets, least significant bits first.
// The operation travels in s_axis_tuser (0 byte, 1 word, 2 flush, 3 ignored) and
// the value in s_axis_tdata; a byte uses only bits 7:0. Each byte or word beat
// emits every sextet it completes, the final one of that item marked by
// m_axis_tlast; up to five leftover bits wait for the next item. A flush emits
// the partial sextet, upper bits zero, when bits are pending, and empties the
// state. Output sextets sit in bits 5:0 of m_axis_tdata with bits 7:6 zero.
// The accumulator emits one sextet per cycle while the output register can take
// it, so an item keeps the back end busy until it has emitted its sextets: a
// byte yields 1 or 2, a word 5 or 6, a flush 1, or none when nothing is pending.
// The next item is loaded in the same cycle as the previous item's last sextet,
// and a two-beat queue lets input beats keep arriving while the accumulator works
// or the output register is stalled. A registered output holds each sextet; an
// input beat passes the queue and the accumulator before its first sextet.
module sextet_bit_packer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // value[31:0]
    input  logic [1:0]  s_axis_tuser,   // operation[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // sextet[5:0], zeros in [7:6]
    output logic        m_axis_tlast    // last sextet of the item
);
    import sbp_pkg::*;

    // front to queue
    logic       push;
    sbp_entry_t push_entry;
    logic       q_full;

    // queue to back
    logic       pop;
    logic       head_valid;
    sbp_entry_t head_entry;

    // decode and mask each input beat
    sbp_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_full        (q_full),
        .q_push        (push),
        .q_entry       (push_entry)
    );

    // decouples input acceptance from sextet emission
    sbp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    // pending bits, accumulator and output register
    sbp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (head_valid),
        .q_entry       (head_entry),
        .q_pop         (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// File: verif/testbench.sv
// self-checking testbench for sextet_bit_packer: streams byte, word and flush beats
// depends on sbp_pkg and the sextet_bit_packer rtl; a scoreboard class predicts sextets
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import sbp_pkg::*;

    // one expected output beat
    typedef struct packed {
        logic [SEXTET_W-1:0] sextet;
        logic                last;
    } sextet_beat_t;

    // predicts the sextet stream and checks what comes out of the block
    class sextet_scoreboard;
        logic [PEND_W-1:0] held_bits;
        logic [CNT_W-1:0]  held_count;
        sextet_beat_t      expected_sextets[$];
        int                errors;
        int                checked;
        int                op_seen[4];

        function new();
            held_bits  = '0;
            held_count = '0;
            errors     = 0;
            checked    = 0;
            foreach (op_seen[i]) op_seen[i] = 0;
        endfunction

        // accepted input beat: returns the number of sextets it causes
        function int note_item(logic [OP_W-1:0] op, logic [WORD_W-1:0] val);
            logic [ACC_W-1:0] acc;
            logic [WORD_W-1:0] data;
            sextet_beat_t      beat;
            int                total;
            int                n;
            n = 0;
            op_seen[op]++;
            case (op)
                OP_BYTE, OP_WORD:
                begin
                    data  = (op == OP_BYTE) ? {24'b0, val[BYTE_W-1:0]} : val;
                    total = int'(held_count) + ((op == OP_BYTE) ? BYTE_W : WORD_W);
                    // new bits sit above the held ones
                    acc = {{WORD_W{1'b0}}, held_bits} | ({{PEND_W{1'b0}}, data} << held_count);
                    while (total >= SEXTET_W)
                    begin
                        beat.sextet = acc[SEXTET_W-1:0];
                        beat.last   = (total < 2 * SEXTET_W);
                        expected_sextets.push_back(beat);
                        acc   = acc >> SEXTET_W;
                        total = total - SEXTET_W;
                        n++;
                    end
                    held_count = CNT_W'(total);
                    held_bits  = acc[PEND_W-1:0];
                end
                OP_FLUSH:
                begin
                    if (held_count != 0)
                    begin
                        beat.sextet = {1'b0, held_bits};
                        beat.last   = 1'b1;
                        expected_sextets.push_back(beat);
                        n = 1;
                    end
                    held_bits  = '0;
                    held_count = '0;
                end
                default: ;
            endcase
            return n;
        endfunction

        function void check_sextet(logic [OUT_W-1:0] data, logic last);
            sextet_beat_t want;
            if (expected_sextets.size() == 0)
            begin
                $error("unexpected sextet beat: data %0h last %0b", data, last);
                errors++;
                return;
            end
            want = expected_sextets.pop_front();
            checked++;
            if (data[SEXTET_W-1:0] !== want.sextet)
            begin
                $error("sextet mismatch: expected %0h, actual %0h", want.sextet,
                       data[SEXTET_W-1:0]);
                errors++;
            end
            if (data[OUT_W-1:SEXTET_W] !== '0)
            begin
                $error("pad mismatch: expected 0, actual %0h", data[OUT_W-1:SEXTET_W]);
                errors++;
            end
            if (last !== want.last)
            begin
                $error("last mismatch: expected %0b, actual %0b", want.last, last);
                errors++;
            end
        endfunction

        function int outstanding();
            return expected_sextets.size();
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [WORD_W-1:0] s_data = '0;
    logic [OP_W-1:0]   s_user = OP_BYTE;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [OUT_W-1:0]  m_data;
    logic              m_last;

    sextet_scoreboard sb = new();

    bit quiet = 1'b0;          // no idling on either side
    bit long_hold_req = 1'b0;  // asks the receiver for one long stall

    sextet_bit_packer DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),   // value[31:0]
        .s_axis_tuser  (s_user),   // operation[1:0]
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),   // sextet[5:0], zeros in [7:6]
        .m_axis_tlast  (m_last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // safety net against a hung handshake
    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    // output monitor
    always @(posedge clk)
    begin
        if (rst_n && m_valid && m_ready)
            sb.check_sextet(m_data, m_last);
    end

    // receiver: random stall bursts, one long hold on request, none when quiet
    initial
    begin
        forever
        begin
            if (long_hold_req)
            begin
                // long hold so the queue fills and the input stalls
                m_ready <= 1'b0;
                repeat (80) @(posedge clk);
                long_hold_req = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            else
            begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    // drive one beat, wait for the handshake, then maybe idle a burst
    task automatic send_item(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] val);
        int gap;
        s_valid <= 1'b1;
        s_user  <= op;
        s_data  <= val;
        do
            @(posedge clk);
        while (!s_ready);
        void'(sb.note_item(op, val));
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 14);
            s_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int          sent;
        int          r;
        bit          paused;
        logic [OP_W-1:0]   op;
        logic [WORD_W-1:0] val;

        sent   = 0;
        paused = 1'b0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        send_item(OP_FLUSH, 32'hffff_ffff);  // flush with nothing held: silent
        send_item(OP_NONE,  32'hffff_ffff);  // unused code: ignored
        send_item(OP_BYTE,  32'hffff_ff00);  // upper bits of a byte are dropped
        send_item(OP_BYTE,  32'h0000_00ff);  // four bits left over
        send_item(OP_WORD,  32'hffff_ffff);  // four held plus a word: six sextets
        send_item(OP_WORD,  32'h0000_0000);
        send_item(OP_WORD,  32'h1234_5678);
        send_item(OP_NONE,  32'h0000_0000);  // ignored with bits held
        send_item(OP_BYTE,  32'h0000_003c);  // twelve bits: two sextets
        send_item(OP_BYTE,  32'habcd_ef81);
        send_item(OP_FLUSH, 32'h0000_0000);  // partial sextet, upper bits zero
        send_item(OP_FLUSH, 32'h5555_5555);
        send_item(OP_BYTE,  32'h0000_0055);
        send_item(OP_BYTE,  32'h0000_00aa);
        send_item(OP_FLUSH, 32'h0000_0000);  // flush with four held
        send_item(OP_WORD,  32'h8000_0001);
        send_item(OP_BYTE,  32'h0000_0080);
        send_item(OP_WORD,  32'hdead_beef);
        send_item(OP_FLUSH, 32'h0000_0000);
        send_item(OP_WORD,  32'ha5a5_5a5a);

        // back-to-back words against a long output stall
        s_valid <= 1'b0;
        @(posedge clk);
        long_hold_req = 1'b1;
        for (int i = 0; i < 12; i++)
        begin
            op = OP_WORD;
            send_item(op, $urandom());
        end

        // random part
        while (sent < 188)
        begin
            if (sent >= 150)
                quiet = 1'b1;
            if (!paused && sent >= 90)
            begin
                // sender holds off until every sextet has come out
                paused = 1'b1;
                s_valid <= 1'b0;
                @(posedge clk);
                wait_drained();
            end
            r  = $urandom_range(0, 99);
            op = (r < 40) ? OP_BYTE : (r < 75) ? OP_WORD : (r < 90) ? OP_FLUSH : OP_NONE;
            r  = $urandom_range(0, 9);
            val = (r == 0) ? 32'h0 : (r == 1) ? 32'hffff_ffff : 32'($urandom());
            send_item(op, val);
            sent++;
        end
        s_valid <= 1'b0;

        wait_drained();
        repeat (20) @(posedge clk);

        if (sb.outstanding() != 0)
        begin
            $error("%0d expected sextets never arrived", sb.outstanding());
            sb.errors++;
        end

        $display("beats sent: %0d byte, %0d word, %0d flush, %0d unused op",
                 sb.op_seen[OP_BYTE], sb.op_seen[OP_WORD], sb.op_seen[OP_FLUSH],
                 sb.op_seen[OP_NONE]);
        $display("sextets checked: %0d, with random stalls, one long hold and a drain pause",
                 sb.checked);
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
